### rtl/core/p4rgb_pkg.sv
// ----------------------------------------------------------------------------
// p4rgb_pkg
// Shared types, constants and helpers for the 4bpp palette to RGB565 expander.
// ----------------------------------------------------------------------------
package p4rgb_pkg;

   localparam int unsigned WidthBits   = 12;
   localparam int unsigned PalDepth    = 16;
   localparam int unsigned PalAddrBits = 4;
   localparam int unsigned PixelBits   = 16;
   localparam int unsigned FifoDepth   = 4;
   localparam int unsigned FifoPtrBits = 2;
   localparam int unsigned FifoCntBits = 3;
   localparam int unsigned ReqDataBits = 40;
   localparam int unsigned CsrAddrBits = 3;
   localparam int unsigned CsrDataBits = 32;

   typedef enum logic {
      CMD_PIXEL_BYTE = 1'b0,
      CMD_PAL_WRITE  = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_UNMAPPED    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                 last_of_item;
      logic                 end_of_row;
      logic [PixelBits-1:0] pixel;
   } rsp_word_type;

   // Byte-swapped RGB565: {g[2:0], b[4:0]} in the high byte, {r[4:0], g[5:3]} low.
   function automatic logic [PixelBits-1:0] make_entry(input logic [7:0] blue,
                                                       input logic [7:0] green,
                                                       input logic [7:0] red);
      logic [5:0] g6;
      g6 = green[7:2];
      make_entry = {g6[2:0], blue[7:3], red[7:3], g6[5:3]};
   endfunction

endpackage

### rtl/core/palette_4bpp_to_rgb565_expander.sv
// ----------------------------------------------------------------------------
// palette_4bpp_to_rgb565_expander
// Expands a stream of packed 4bpp bitmap bytes into byte-swapped RGB565 words.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one word per packed byte or palette write. req_tuser selects
//    the kind: 0 = pixel byte (high nibble pixel first, then low nibble),
//    1 = palette write of a blue/green/red triple to one of 16 entries.
//  - rsp_* carries one RGB565 word per pixel; rsp_tlast marks the last pixel of
//    a bitmap row, rsp_tuser marks the last pixel produced by one input byte.
//  - csr_* (APB) holds image_width at address 0. Write it only while idle.
//  - Throughput: one pixel per cycle while the output queue has room. A byte
//    with two pixels holds req_tready low until its second read issues; other
//    input words do not. The palette memory's single read port sets that rate.
//  - Path: the first pixel of a byte passes the issue registers, the memory
//    read register and the output queue before rsp_tvalid rises for it; a full
//    queue can hold it in the issue stage.
//  - Reset clears the row position, sets image_width to 1 and marks every
//    palette entry as unwritten (reads as zero). No clearing pass is needed.
//  - When the receiver stalls, results collect in a 4-word output queue; issue
//    of palette reads halts on a credit count, then req_tready drops.
// ----------------------------------------------------------------------------
module palette_4bpp_to_rgb565_expander (
   input  logic                               clock,
   input  logic                               reset,
   // Input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] data_byte, [11:8] pal_index, [19:12] pal_blue, [27:20] pal_green,
   // [35:28] pal_red, [39:36] zero
   input  logic [p4rgb_pkg::ReqDataBits-1:0]  req_tdata,
   // [0] command
   input  logic                               req_tuser,
   // Result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] pixel
   output logic [p4rgb_pkg::PixelBits-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // [0] last_of_item
   output logic                               rsp_tuser,
   // Configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [p4rgb_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [p4rgb_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [p4rgb_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import p4rgb_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [WidthBits-1:0] width_ff, width_in;
   reg_index_type        csr_reg;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_reg    = reg_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in   = width_ff;
      csr_prdata = '0;
      case (csr_reg)
         REG_IMAGE_WIDTH: begin
            if (csr_wr) begin
               width_in = csr_pwdata[WidthBits-1:0];
            end
            csr_prdata = {{(CsrDataBits-WidthBits){1'b0}}, width_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Input decode and row position
   // ---------------------------------------------------------------------
   logic [7:0]             in_byte;
   logic [PalAddrBits-1:0] in_pal_index;
   logic [7:0]             in_blue, in_green, in_red;
   cmd_type                in_cmd;
   logic                   req_fire;

   assign in_byte      = req_tdata[7:0];
   assign in_pal_index = req_tdata[11:8];
   assign in_blue      = req_tdata[19:12];
   assign in_green     = req_tdata[27:20];
   assign in_red       = req_tdata[35:28];
   assign in_cmd       = cmd_type'(req_tuser);
   assign req_fire     = req_tvalid && req_tready;

   logic [WidthBits-1:0] pos_ff, pos_in;
   logic [WidthBits:0]   w_ext, width_plus7, first_pix, pos_plus1;
   logic [WidthBits-1:0] stride;
   logic                 in_stride, has_p0, has_p1, eor_p0, eor_p1;

   always_comb begin
      w_ext       = {1'b0, width_ff};
      width_plus7 = w_ext + (WidthBits+1)'(7);
      // Stride in bytes: ((width + 7) / 8) * 4
      stride      = {width_plus7[WidthBits:3], 2'b00};
      first_pix   = {pos_ff, 1'b0};
      pos_plus1   = {1'b0, pos_ff} + (WidthBits+1)'(1);
      in_stride   = pos_ff < stride;
      has_p0      = in_stride && (first_pix < w_ext);
      has_p1      = in_stride && ((first_pix + (WidthBits+1)'(1)) < w_ext);
      eor_p0      = (first_pix + (WidthBits+1)'(1)) == w_ext;
      eor_p1      = (first_pix + (WidthBits+1)'(2)) == w_ext;

      pos_in = pos_ff;
      if (req_fire && in_cmd == CMD_PIXEL_BYTE) begin
         // Wrap at the end of the stride; hold at zero when the stride is empty.
         if (pos_plus1 >= {1'b0, stride}) begin
            pos_in = '0;
         end else begin
            pos_in = pos_plus1[WidthBits-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Issue stage: one memory operation per cycle, in arrival order
   // ---------------------------------------------------------------------
   logic [1:0]             iss_cnt_ff, iss_cnt_in;
   logic                   iss_pal_ff, iss_pal_in;
   logic [PalAddrBits-1:0] iss_idx_ff [2];
   logic [PalAddrBits-1:0] iss_idx_in [2];
   logic [1:0]             iss_eor_ff, iss_eor_in;
   logic [PalAddrBits-1:0] iss_wadr_ff, iss_wadr_in;
   logic [PixelBits-1:0]   iss_entry_ff, iss_entry_in;
   logic                   iss_fire, credit_ok;

   logic                   rd_vld_ff;
   logic [FifoCntBits-1:0] fifo_cnt_ff, fifo_cnt_in;

   // Reserve a queue slot for every read in flight.
   assign credit_ok = (fifo_cnt_ff + FifoCntBits'(rd_vld_ff)) < FifoCntBits'(FifoDepth);
   assign iss_fire  = (iss_cnt_ff != 2'd0) && credit_ok;

   assign req_tready = iss_pal_ff
                    || (iss_cnt_ff == 2'd0)
                    || (iss_fire && iss_cnt_ff == 2'd1);

   always_comb begin
      iss_cnt_in    = iss_cnt_ff;
      iss_pal_in    = 1'b0;
      iss_idx_in[0] = iss_idx_ff[0];
      iss_idx_in[1] = iss_idx_ff[1];
      iss_eor_in    = iss_eor_ff;
      iss_wadr_in   = iss_wadr_ff;
      iss_entry_in  = iss_entry_ff;

      if (iss_fire) begin
         // Advance: the second pixel moves into the head slot.
         iss_cnt_in    = iss_cnt_ff - 2'd1;
         iss_idx_in[0] = iss_idx_ff[1];
         iss_eor_in    = {1'b0, iss_eor_ff[1]};
      end

      if (req_fire) begin
         case (in_cmd)
            CMD_PAL_WRITE: begin
               iss_pal_in   = 1'b1;
               iss_cnt_in   = 2'd0;
               iss_wadr_in  = in_pal_index;
               iss_entry_in = make_entry(in_blue, in_green, in_red);
            end
            default: begin
               iss_cnt_in    = {1'b0, has_p0} + {1'b0, has_p1};
               iss_idx_in[0] = in_byte[7:4];
               iss_idx_in[1] = in_byte[3:0];
               iss_eor_in    = {eor_p1, eor_p0};
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Palette memory: one write or one read per cycle, read data registered
   // ---------------------------------------------------------------------
   logic [PixelBits-1:0] pal_mem [PalDepth];
   logic [PalDepth-1:0]  pal_vld_ff;
   logic [PixelBits-1:0] rd_data_ff;
   logic                 rd_ok_ff, rd_eor_ff, rd_last_ff;
   rsp_word_type         rd_word;

   always_ff @(posedge clock) begin
      if (iss_pal_ff) begin
         pal_mem[iss_wadr_ff] <= iss_entry_ff;
      end
      if (iss_fire) begin
         rd_data_ff <= pal_mem[iss_idx_ff[0]];
         rd_ok_ff   <= pal_vld_ff[iss_idx_ff[0]];
         rd_eor_ff  <= iss_eor_ff[0];
         rd_last_ff <= (iss_cnt_ff == 2'd1);
      end
   end

   // An entry never written reads as zero.
   assign rd_word.pixel        = rd_ok_ff ? rd_data_ff : '0;
   assign rd_word.end_of_row   = rd_eor_ff;
   assign rd_word.last_of_item = rd_last_ff;

   // ---------------------------------------------------------------------
   // Output queue
   // ---------------------------------------------------------------------
   rsp_word_type           fifo_mem [FifoDepth];
   logic [FifoPtrBits-1:0] fifo_wp_ff, fifo_rp_ff;
   logic                   fifo_push, fifo_pop;
   rsp_word_type           head;

   assign fifo_push   = rd_vld_ff;
   assign fifo_pop    = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + FifoCntBits'(fifo_push) - FifoCntBits'(fifo_pop);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[fifo_wp_ff] <= rd_word;
      end
   end

   assign head       = fifo_mem[fifo_rp_ff];
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tdata  = head.pixel;
   assign rsp_tlast  = head.end_of_row;
   assign rsp_tuser  = head.last_of_item;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WidthBits'(1);
         pos_ff      <= '0;
         iss_cnt_ff  <= '0;
         iss_pal_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         pal_vld_ff  <= '0;
         fifo_cnt_ff <= '0;
         fifo_wp_ff  <= '0;
         fifo_rp_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         pos_ff      <= pos_in;
         iss_cnt_ff  <= iss_cnt_in;
         iss_pal_ff  <= iss_pal_in;
         rd_vld_ff   <= iss_fire;
         if (iss_pal_ff) begin
            pal_vld_ff[iss_wadr_ff] <= 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_in;
         if (fifo_push) begin
            fifo_wp_ff <= fifo_wp_ff + FifoPtrBits'(1);
         end
         if (fifo_pop) begin
            fifo_rp_ff <= fifo_rp_ff + FifoPtrBits'(1);
         end
      end
   end

   // Payload registers of the issue stage
   always_ff @(posedge clock) begin
      iss_idx_ff[0] <= iss_idx_in[0];
      iss_idx_ff[1] <= iss_idx_in[1];
      iss_eor_ff    <= iss_eor_in;
      iss_wadr_ff   <= iss_wadr_in;
      iss_entry_ff  <= iss_entry_in;
   end

endmodule
